[sv/acd_pkg.sv]
// Shared constants, types and the back-end state encoding for the box contact detector.
// No dependencies; imported by every module of the block.
package acd_pkg;

  localparam int MAX_BOXES = 32;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;
  localparam logic signed [1:0] NORM_ZERO = 2'sb00;

  // One stored box.
  typedef struct packed {
    logic        [31:0] id;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

  // One classified item waiting for the scan.
  typedef struct packed {
    box_t             box;
    logic [IDX_W-1:0] limit;   // number of stored boxes to compare against
    logic             wr_en;   // store the box after the scan
    logic [IDX_W-1:0] wr_idx;  // slot it goes to
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_WRITE
  } back_state_t;

endpackage

[sv/acd_front.sv]
// Front end: accepts boxes, tracks the frame's box count and classifies each item.
// Depends on acd_pkg.
module acd_front
  import acd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               frame_start,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic        [31:0] entity_id,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item
);

  logic [CNT_W-1:0] box_count;
  logic [CNT_W-1:0] base_count;
  logic             room;

  assign push       = start && !q_full;
  assign base_count = frame_start ? '0 : box_count;
  assign room       = base_count < CNT_W'(MAX_BOXES);

  always_comb begin
    push_item.box.id    = entity_id;
    push_item.box.min_x = box_min_x;
    push_item.box.min_y = box_min_y;
    push_item.box.max_x = box_max_x;
    push_item.box.max_y = box_max_y;
    // compare against at most MAX_BOXES-1 stored boxes
    if (base_count > CNT_W'(MAX_BOXES - 1)) begin
      push_item.limit = IDX_W'(MAX_BOXES - 1);
    end else begin
      push_item.limit = base_count[IDX_W-1:0];
    end
    push_item.wr_en  = room;
    push_item.wr_idx = base_count[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (push) begin
      box_count <= room ? base_count + CNT_W'(1) : base_count;
    end
  end

endmodule

[sv/acd_queue.sv]
// Two-entry item queue between the front end and the scan engine.
// Depends on acd_pkg.
module acd_queue
  import acd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign empty = count == 2'd0;
  assign full  = count == 2'd2;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[sv/acd_back.sv]
// Scan engine: box store, one stored box compared per cycle, contact events out.
// Depends on acd_pkg; fed by acd_queue.
module acd_back
  import acd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  item_t              head,
  input  logic               q_empty,
  output logic               pop,
  output logic               result_valid,
  output logic        [31:0] entity_a,
  output logic        [31:0] entity_b,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_y,
  output logic        [31:0] penetration,
  output logic               run_end
);

  back_state_t state;
  back_state_t state_next;

  box_t             store_mem [MAX_BOXES];
  item_t            cur;
  logic [IDX_W-1:0] idx;
  logic             scan_last;
  logic             rd_en;
  logic             wr_en;

  // read stage
  box_t rd_q;
  logic s1_valid;
  logic s1_last;

  // compare stage
  logic                s2_valid;
  logic                s2_last;
  logic                s2_hit;
  logic signed [32:0]  s2_ox;
  logic signed [32:0]  s2_oy;
  logic                s2_sx;
  logic                s2_sy;
  logic [31:0]         s2_ida;

  // held event, released once the next one or the end of the scan is known
  logic                pend_valid;
  logic [31:0]         pend_a;
  logic signed [1:0]   pend_nx;
  logic signed [1:0]   pend_ny;
  logic [31:0]         pend_pen;
  logic                flush;

  logic                hit1;
  logic signed [32:0]  ox1;
  logic signed [32:0]  oy1;
  logic                sx1;
  logic                sy1;
  logic signed [31:0]  lo_x;
  logic signed [31:0]  hi_x;
  logic signed [31:0]  lo_y;
  logic signed [31:0]  hi_y;

  logic                x_axis;
  logic signed [32:0]  pen_raw;
  logic signed [1:0]   new_nx;
  logic signed [1:0]   new_ny;
  logic [31:0]         new_pen;

  assign scan_last = idx == cur.limit - IDX_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (head.limit == '0) ? BK_WRITE : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!s1_valid && !s2_valid && !flush) begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state)
      BK_IDLE:  pop   = !q_empty;
      BK_SCAN:  rd_en = 1'b1;
      BK_DRAIN: ;
      BK_WRITE: wr_en = cur.wr_en;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (pop) begin
      idx <= '0;
    end else if (rd_en) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // box store: read during the scan, written once the scan is done
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[cur.wr_idx] <= cur.box;
    end
    if (rd_en) begin
      rd_q <= store_mem[idx];
    end
  end

  // contact test and per-axis overlap for the stored box in rd_q
  always_comb begin
    hit1 = !(rd_q.max_x < cur.box.min_x || rd_q.min_x > cur.box.max_x ||
             rd_q.max_y < cur.box.min_y || rd_q.min_y > cur.box.max_y);
    lo_x = (rd_q.max_x < cur.box.max_x) ? rd_q.max_x : cur.box.max_x;
    hi_x = (rd_q.min_x > cur.box.min_x) ? rd_q.min_x : cur.box.min_x;
    lo_y = (rd_q.max_y < cur.box.max_y) ? rd_q.max_y : cur.box.max_y;
    hi_y = (rd_q.min_y > cur.box.min_y) ? rd_q.min_y : cur.box.min_y;
    ox1  = 33'(lo_x) - 33'(hi_x);
    oy1  = 33'(lo_y) - 33'(hi_y);
    sx1  = (33'(rd_q.min_x) + 33'(rd_q.max_x)) <
           (33'(cur.box.min_x) + 33'(cur.box.max_x));
    sy1  = (33'(rd_q.min_y) + 33'(rd_q.max_y)) <
           (33'(cur.box.min_y) + 33'(cur.box.max_y));
  end

  // pick the axis; ties go to y, negative overlap clamps to zero
  always_comb begin
    x_axis  = s2_ox < s2_oy;
    pen_raw = x_axis ? s2_ox : s2_oy;
    new_pen = pen_raw[32] ? 32'd0 : pen_raw[31:0];
    if (x_axis) begin
      new_nx = s2_sx ? NORM_POS : NORM_NEG;
      new_ny = NORM_ZERO;
    end else begin
      new_nx = NORM_ZERO;
      new_ny = s2_sy ? NORM_POS : NORM_NEG;
    end
  end

  always_ff @(posedge clk) begin
    s2_hit <= hit1;
    s2_ox  <= ox1;
    s2_oy  <= oy1;
    s2_sx  <= sx1;
    s2_sy  <= sy1;
    s2_ida <= rd_q.id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_last      <= 1'b0;
      s2_valid     <= 1'b0;
      s2_last      <= 1'b0;
      flush        <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= rd_en;
      s1_last      <= rd_en && scan_last;
      s2_valid     <= s1_valid;
      s2_last      <= s1_valid && s1_last;
      flush        <= s2_valid && s2_last;
      result_valid <= 1'b0;
      if (s2_valid && s2_hit) begin
        // release the older event, hold the new one
        result_valid <= pend_valid;
        pend_valid   <= 1'b1;
      end else if (flush && pend_valid) begin
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_hit) begin
      entity_a    <= pend_a;
      normal_x    <= pend_nx;
      normal_y    <= pend_ny;
      penetration <= pend_pen;
      run_end     <= 1'b0;
      pend_a      <= s2_ida;
      pend_nx     <= new_nx;
      pend_ny     <= new_ny;
      pend_pen    <= new_pen;
    end else if (flush) begin
      entity_a    <= pend_a;
      normal_x    <= pend_nx;
      normal_y    <= pend_ny;
      penetration <= pend_pen;
      run_end     <= 1'b1;
    end
    entity_b <= cur.box.id;
  end

endmodule

[sv/aabb_pair_collision_detect.sv]
// Top level of the 2D box contact detector: front end, item queue and scan engine.
// Depends on acd_pkg, acd_front, acd_queue and acd_back.
//
// Usage: drive start with a box (frame_start, edges in signed Q16.16,
// entity_id); the box is taken at a rising edge where start is high and busy
// is low. frame_start empties the store before that box is handled.
// Each box is compared against up to MAX_BOXES-1 boxes stored earlier in the
// frame, then stored if there is room. Every touching pair gives one event on
// entity_a/entity_b/normal_x/normal_y/penetration/run_end, shown for exactly
// one cycle with result_valid high; run_end marks the last event of a box,
// and a box with no contact gives no event.
// Scan: the scan engine reads one stored box per cycle from its single-ported
// store. A box is loaded, then its stored boxes are read and the compare
// pipeline drains and releases the held event (skipped when there is nothing
// to compare), then the store write follows. Each event is held until the
// next hit or the end of the scan is known. A two-entry queue lets the front
// end accept boxes while the scan engine works; busy rises when that queue is
// full. Reset (rst, synchronous) empties the queue, clears the box count and
// drops any event in flight. The receiver cannot stall; no event waits for it.
module aabb_pair_collision_detect
  import acd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               frame_start,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic        [31:0] entity_id,
  output logic               result_valid,
  output logic        [31:0] entity_a,
  output logic        [31:0] entity_b,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_y,
  output logic        [31:0] penetration,
  output logic               run_end
);

  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  q_empty;
  logic  q_full;

  assign busy = q_full;

  acd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .frame_start (frame_start),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y),
    .entity_id   (entity_id),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  acd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  acd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .entity_a     (entity_a),
    .entity_b     (entity_b),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .penetration  (penetration),
    .run_end      (run_end)
  );

endmodule
